@@ hdl/psgrwd_pkg.sv @@
package psgrwd_pkg;

  // channel count and the noise channel
  localparam int unsigned NumChannels = 4;
  localparam logic [1:0] NoiseChannel = 2'd3;

  // slot range of the sample buffer
  localparam int unsigned BufferDepth = 4096;

  // reset values of the per-channel state
  localparam logic [9:0] ToneReset = 10'd1;
  localparam logic [3:0] AttenReset = 4'd15;

  // level on a modulation marker
  localparam logic [4:0] ModLevel = 5'd31;

  // input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] buffer_pos;
  } psg_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]  channel_index;
    logic [11:0] slot;
    logic        tone_changed;
    logic [9:0]  tone_value;
    logic        volume_changed;
    logic [4:0]  volume_level;
    logic        modulation_on;
  } psg_out_t;

  // attenuation to amplitude, floor((15 - a) * 31 / 15)
  localparam logic [4:0] VolLut [16] = '{
    5'd31, 5'd28, 5'd26, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
    5'd14, 5'd12, 5'd10, 5'd8,  5'd6,  5'd4,  5'd2,  5'd0
  };

endpackage

@@ hdl/psg_register_write_decoder_top.sv @@
// Register-write decoder for a four-channel sound generator (channel 3 is noise).
// Input channel: in_valid_i / in_stall_o carry one port byte and its buffer slot
// per beat. Output channel: out_valid_o / out_stall_i carry one event per beat:
// a tone change, a volume change or a modulation marker for the written channel.
// A beat is taken at a rising edge with valid high and stall low.
// Path: an accepted byte lands in the input register; when it advances, the
// channel state is updated and the event is loaded into the result register,
// from which it is offered. Throughput: one byte per cycle while the receiver
// does not stall; the decode and state update are a single pass of short logic
// between the input register and the result register.
// While the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; in_stall_o rises only when both are full
// and the receiver stalls.
// Reset: both registers empty, latched channel 0 in tone mode, channel
// registers 0, tones 1, modulation flags clear.
module psg_register_write_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psgrwd_pkg::psg_in_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psgrwd_pkg::psg_out_t out_data_o
);

  // handshake registers
  logic                 in_valid_q;
  psgrwd_pkg::psg_in_t  in_q;
  logic                 out_valid_q;
  psgrwd_pkg::psg_out_t out_q;
  psgrwd_pkg::psg_out_t out_d;

  // channel state
  logic [1:0] lat_ch_q;
  logic       lat_vol_q;
  logic [9:0] chan_reg_q  [psgrwd_pkg::NumChannels];
  logic [9:0] tone_q      [psgrwd_pkg::NumChannels];
  logic [3:0] mod_q;

  // decode signals
  logic       advance;
  logic       in_take;
  logic       is_latch;
  logic [1:0] ch;
  logic       is_vol;
  logic [9:0] reg_new;
  logic       tone_ev;
  logic       mod_ev;
  logic       vol_ev;
  logic       mod_new;

  // pipeline flow
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // decode the held byte
  always_comb begin
    is_latch = in_q.data_byte[7];
    ch       = is_latch ? in_q.data_byte[6:5] : lat_ch_q;
    is_vol   = is_latch ? in_q.data_byte[4] : lat_vol_q;
    reg_new  = is_latch ? {chan_reg_q[ch][9:4], in_q.data_byte[3:0]}
                        : {in_q.data_byte[5:0], chan_reg_q[ch][3:0]};
    tone_ev  = !is_vol;
    mod_ev   = is_latch && is_vol && (tone_q[ch] == 10'd0);
    vol_ev   = is_vol && !mod_ev;
    if (tone_ev) begin
      mod_new = 1'b0;
    end else if (mod_ev) begin
      mod_new = 1'b1;
    end else begin
      mod_new = mod_q[ch];
    end
  end

  // result beat
  always_comb begin
    out_d.channel_index  = ch;
    out_d.slot           = 12'(in_q.buffer_pos % psgrwd_pkg::BufferDepth);
    out_d.tone_changed   = tone_ev || mod_ev;
    out_d.volume_changed = vol_ev || mod_ev;
    out_d.modulation_on  = mod_new;
    if (tone_ev) begin
      if (reg_new != 10'd0 || ch == psgrwd_pkg::NoiseChannel) begin
        out_d.tone_value = reg_new;
      end else begin
        out_d.tone_value = psgrwd_pkg::ToneReset;
      end
    end else if (mod_ev) begin
      out_d.tone_value = {6'd0, reg_new[3:0]};
    end else begin
      out_d.tone_value = 10'd0;
    end
    if (mod_ev) begin
      out_d.volume_level = psgrwd_pkg::ModLevel;
    end else if (vol_ev) begin
      out_d.volume_level = psgrwd_pkg::VolLut[in_q.data_byte[3:0]];
    end else begin
      out_d.volume_level = 5'd0;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_ch_q  <= 2'd0;
      lat_vol_q <= 1'b0;
      mod_q     <= '0;
      for (int i = 0; i < psgrwd_pkg::NumChannels; i++) begin
        chan_reg_q[i] <= 10'd0;
        tone_q[i]     <= psgrwd_pkg::ToneReset;
      end
    end else if (advance) begin
      lat_ch_q       <= ch;
      lat_vol_q      <= is_vol;
      chan_reg_q[ch] <= reg_new;
      mod_q[ch]      <= mod_new;
      if (tone_ev) begin
        tone_q[ch] <= reg_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // every beat carries at least one event flag
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.tone_changed || out_q.volume_changed))
    else $error("result beat carries no event");

  // a modulation marker shows full level and a set flag
  a_mod_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.tone_changed && out_q.volume_changed)
      |-> (out_q.volume_level == psgrwd_pkg::ModLevel && out_q.modulation_on))
    else $error("modulation marker malformed");

  // a plain tone change on a tone channel is never zero and clears modulation
  a_tone_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.tone_changed && !out_q.volume_changed
      && out_q.channel_index != psgrwd_pkg::NoiseChannel)
      |-> (out_q.tone_value != 10'd0 && !out_q.modulation_on))
    else $error("tone change gives zero tone or keeps modulation");

  // a byte in the input register with room ahead reaches the result register
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("held byte did not advance");

  // modulation is only ever set on a channel whose tone is zero
  for (genvar g = 0; g < psgrwd_pkg::NumChannels; g++) begin : g_mod_chk
    a_mod_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mod_q[g] |-> (tone_q[g] == 10'd0))
      else $error("modulation flag set on nonzero tone");
  end
`endif

endmodule
